### hw/rtl/cartridge_bank_irq_mapper_defines.svh
// Assertion macros used by the cartridge mapper top-level RTL.
`ifndef CARTRIDGE_BANK_IRQ_MAPPER_DEFINES_SVH
`define CARTRIDGE_BANK_IRQ_MAPPER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk and switched off during reset.
`define CBIM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbim: implication check failed");
// Next-cycle implication, sampled on clk and switched off during reset.
`define CBIM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbim: next-cycle check failed");
`else
`define CBIM_ASSERT_IMP(lbl, ante, cons)
`define CBIM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

### hw/rtl/cbim_pkg.sv
// Types and constants of the cartridge bank and IRQ mapper.
`default_nettype none
package cbim_pkg;

  localparam int KIND_W  = 2;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int BANK_W  = 3;
  localparam int CNT_W   = 16;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // Register pages and addresses.
  localparam logic [7:0]        PAGE_BANK_LATCH  = 8'h4A;
  localparam logic [7:0]        PAGE_BANK_COMMIT = 8'h51;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_LO      = 16'h4020;
  localparam logic [ADDR_W-1:0] ADDR_IRQ_HI      = 16'h4021;
  localparam logic [ADDR_W-1:0] ADDR_MIRROR      = 16'h4025;
  localparam logic [ADDR_W-1:0] ADDR_STATUS      = 16'h4030;
  localparam int                MIRROR_BIT       = 3;

  // Result buffer depth and the width of its fill count.
  localparam int OBUF_DEPTH = 2;
  localparam int OBUF_CNT_W = $clog2(OBUF_DEPTH + 1);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] value;
  } cbim_item_t;

  typedef struct packed {
    logic [BANK_W-1:0] prg_bank_low;
    logic              mirror_horizontal;
    logic              irq_line;
    logic              status_valid;
    logic              irq_status_read;
  } cbim_result_t;

  typedef struct packed {
    logic         valid;
    cbim_result_t result;
  } cbim_push_t;

  typedef struct packed {
    logic armed;
    logic pending;
  } cbim_irq_stat_t;

endpackage
`default_nettype wire

### hw/rtl/cbim_if.sv
// Valid/ready channel interfaces for the mapper's input and result words.
`default_nettype none
interface cbim_in_if import cbim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ADDR_W-1:0] address;
  logic [DATA_W-1:0] value;

  modport source (output valid, output kind, output address, output value, input ready);
  modport sink   (input valid, input kind, input address, input value, output ready);
endinterface

interface cbim_out_if import cbim_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BANK_W-1:0] prg_bank_low;
  logic              mirror_horizontal;
  logic              irq_line;
  logic              status_valid;
  logic              irq_status_read;

  modport source (output valid, output prg_bank_low, output mirror_horizontal,
                  output irq_line, output status_valid, output irq_status_read,
                  input ready);
  modport sink   (input valid, input prg_bank_low, input mirror_horizontal,
                  input irq_line, input status_valid, input irq_status_read,
                  output ready);
endinterface
`default_nettype wire

### hw/rtl/cartridge_bank_irq_mapper.sv
// A word accepted into the stage-one register is applied by the core and written into
// the result buffer, which drives the output. Throughput: one word per clock while the
// buffer has room; the input register, state update and two-entry buffer each take one word per cycle.
// Reset: synchronous, active low; clears all mapper state, the input stage and the buffer.
// There is no clearing pass, so words are accepted in the first cycle after reset.
`default_nettype none
`include "cartridge_bank_irq_mapper_defines.svh"
module cartridge_bank_irq_mapper import cbim_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  cbim_in_if.sink    in_bus,
  cbim_out_if.source out_bus
);

  // Stage one holds the accepted bus word. It moves into the core whenever the
  // result buffer has a free entry; the buffer's fill count is registered, so the
  // input ready never depends combinationally on the output ready.
  logic           s1_valid_r, s1_valid_nxt;
  cbim_item_t     s1_item_r;
  logic           room;
  logic           advance;
  logic           in_accept;
  cbim_push_t     push;
  cbim_irq_stat_t irq_stat;

  assign advance      = s1_valid_r && room;
  assign in_bus.ready = !s1_valid_r || room;
  assign in_accept    = in_bus.valid && in_bus.ready;

  always_comb begin
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // The payload register needs no reset; it is only used while the valid bit is set.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r.kind    <= in_bus.kind;
      s1_item_r.address <= in_bus.address;
      s1_item_r.value   <= in_bus.value;
    end
  end

  // Bank, mirroring and IRQ state, updated once per word as it leaves stage one.
  cbim_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .advance  (advance),
    .item     (s1_item_r),
    .push     (push),
    .irq_stat (irq_stat)
  );

  // Result words wait here until the consumer takes them.
  cbim_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .has_room (room),
    .out_bus  (out_bus)
  );

  // A status read clears the pending flag, so its word never shows the IRQ line high.
  `CBIM_ASSERT_IMP(a_status_clears_line, out_bus.valid && out_bus.status_valid, !out_bus.irq_line)
  // The read-back flag is only ever set on a status read word.
  `CBIM_ASSERT_IMP(a_seen_needs_status, out_bus.valid && out_bus.irq_status_read, out_bus.status_valid)
  // The IRQ goes pending only when the counter expires, which disarms it in the same cycle.
  `CBIM_ASSERT_IMP(a_pending_disarms, $rose(irq_stat.pending), $fell(irq_stat.armed))
  // A word held in stage one while the buffer is full must not be dropped.
  `CBIM_ASSERT_NXT(a_stage_holds, s1_valid_r && !room, s1_valid_r)

endmodule
`default_nettype wire

### hw/rtl/cbim_core.sv
// Mapper state registers and the per-word update logic.
`default_nettype none
module cbim_core import cbim_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,
  input  wire cbim_item_t     item,
  output cbim_push_t          push,
  output cbim_irq_stat_t      irq_stat
);

  logic [BANK_W-1:0] latched_bank_r, latched_bank_nxt;
  logic [BANK_W-1:0] active_bank_r,  active_bank_nxt;
  logic              mirror_r,       mirror_nxt;
  logic [CNT_W-1:0]  counter_r,      counter_nxt;
  logic              armed_r,        armed_nxt;
  logic              pending_r,      pending_nxt;
  logic [CNT_W-1:0]  counter_dec;
  logic              stat_valid;
  logic              stat_seen;

  assign counter_dec = counter_r - CNT_W'(1);

  always_comb begin
    latched_bank_nxt = latched_bank_r;
    active_bank_nxt  = active_bank_r;
    mirror_nxt       = mirror_r;
    counter_nxt      = counter_r;
    armed_nxt        = armed_r;
    pending_nxt      = pending_r;
    stat_valid       = 1'b0;
    stat_seen        = 1'b0;
    case (item.kind)
      KIND_WRITE: begin
        if (item.address[15:8] == PAGE_BANK_LATCH) begin
          latched_bank_nxt = {item.address[6], item.address[3:2]};
        end else if (item.address[15:8] == PAGE_BANK_COMMIT) begin
          active_bank_nxt = latched_bank_r;
        end else if (item.address == ADDR_IRQ_LO) begin
          pending_nxt = 1'b0;
          counter_nxt = {counter_r[15:8], item.value};
        end else if (item.address == ADDR_IRQ_HI) begin
          pending_nxt = 1'b0;
          counter_nxt = {item.value, counter_r[7:0]};
          armed_nxt   = 1'b1;
        end else if (item.address == ADDR_MIRROR) begin
          mirror_nxt = item.value[MIRROR_BIT];
        end
      end
      KIND_READ: begin
        if (item.address == ADDR_STATUS) begin
          stat_valid  = 1'b1;
          stat_seen   = pending_r;
          pending_nxt = 1'b0;
        end
      end
      KIND_TICK: begin
        if (armed_r) begin
          counter_nxt = counter_dec;
          if (counter_dec == '0) begin
            armed_nxt   = 1'b0;
            pending_nxt = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latched_bank_r <= '0;
      active_bank_r  <= '0;
      mirror_r       <= 1'b0;
      counter_r      <= '0;
      armed_r        <= 1'b0;
      pending_r      <= 1'b0;
    end else if (advance) begin
      latched_bank_r <= latched_bank_nxt;
      active_bank_r  <= active_bank_nxt;
      mirror_r       <= mirror_nxt;
      counter_r      <= counter_nxt;
      armed_r        <= armed_nxt;
      pending_r      <= pending_nxt;
    end
  end

  // The result reports the state after the word has been applied.
  always_comb begin
    push.valid                    = advance;
    push.result.prg_bank_low      = active_bank_nxt;
    push.result.mirror_horizontal = mirror_nxt;
    push.result.irq_line          = pending_nxt;
    push.result.status_valid      = stat_valid;
    push.result.irq_status_read   = stat_seen;
  end

  assign irq_stat.armed   = armed_r;
  assign irq_stat.pending = pending_r;

endmodule
`default_nettype wire

### hw/rtl/cbim_out_buf.sv
// Two-entry result buffer that drives the result channel.
`default_nettype none
module cbim_out_buf import cbim_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire cbim_push_t push,
  output logic            has_room,
  cbim_out_if.source      out_bus
);

  cbim_result_t          entry_r [OBUF_DEPTH];
  logic                  wr_ptr_r, wr_ptr_nxt;
  logic                  rd_ptr_r, rd_ptr_nxt;
  logic [OBUF_CNT_W-1:0] cnt_r,    cnt_nxt;
  logic                  pop;
  cbim_result_t          head;

  assign pop      = out_bus.valid && out_bus.ready;
  assign has_room = (cnt_r != OBUF_CNT_W'(OBUF_DEPTH));

  always_comb begin
    wr_ptr_nxt = push.valid ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + OBUF_CNT_W'(push.valid) - OBUF_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      entry_r[wr_ptr_r] <= push.result;
    end
  end

  assign head = entry_r[rd_ptr_r];

  assign out_bus.valid             = (cnt_r != '0);
  assign out_bus.prg_bank_low      = head.prg_bank_low;
  assign out_bus.mirror_horizontal = head.mirror_horizontal;
  assign out_bus.irq_line          = head.irq_line;
  assign out_bus.status_valid      = head.status_valid;
  assign out_bus.irq_status_read   = head.irq_status_read;

endmodule
`default_nettype wire
